// ----- sv/chp_pkg.sv -----
// shared types, sizes and codes of the chained hash table
package chp_pkg;

	// bucket heads and node pool; BUCKETS is a power of two, both at least 2
	localparam int BUCKETS = 1024;
	localparam int POOL    = 1024;
	localparam int BKT_W   = $clog2(BUCKETS);
	localparam int PA_W    = $clog2(POOL);
	localparam int NODE_W  = $clog2(POOL + 1);
	localparam logic [NODE_W-1:0] NULL_NODE = NODE_W'(POOL);
	localparam logic [31:0] ABSENT_VALUE = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_GET    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_UPDATED   = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_REMOVED   = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HEAD,
		S_CMP,
		S_DECIDE,
		S_FREE,
		S_UNLINK,
		S_DONE
	} state_t;

	// classified request as it waits in the queue
	typedef struct packed {
		logic [1:0]       op;
		logic [31:0]      key;
		logic [31:0]      value;
		logic [BKT_W-1:0] bkt;
	} item_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

endpackage

// ----- sv/chp_ram.sv -----
// generic simple dual port ram with registered read
module chp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/chp_front.sv -----
// front end: takes requests, works out the bucket, queues them
module chp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [63:0]         s_tdata,
	input  logic [1:0]          s_tuser,
	output chp_pkg::queue_out_t qout,
	input  logic                pop
);
	import chp_pkg::*;

	item_t       mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic [31:0] key;
	logic [31:0] mag;
	item_t       item;
	logic        push;
	logic        take;

	// bucket from the key magnitude
	always_comb begin
		key        = s_tdata[31:0];
		mag        = key[31] ? (~key + 32'd1) : key;
		item.op    = s_tuser;
		item.key   = key;
		item.value = s_tdata[63:32];
		item.bkt   = mag[BKT_W-1:0];
	end

	assign s_tready   = (cnt_q != 2'd2);
	assign push       = s_tvalid && s_tready;
	assign take       = pop && (cnt_q != 2'd0);
	assign qout.valid = (cnt_q != 2'd0);
	assign qout.item  = mem_q[rd_q];

	// two entry queue
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, take};
		end
	end

endmodule

// ----- sv/chp_back.sv -----
// back end: walks the chain, updates the tables, holds the result
module chp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  chp_pkg::queue_out_t qout,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,
	output logic [2:0]          m_tuser
);
	import chp_pkg::*;

	state_t            state_q, state_d;
	logic [1:0]        op_q;
	logic [31:0]       key_q, val_q, dat_q;
	logic [BKT_W-1:0]  bkt_q, clr_q;
	logic [NODE_W-1:0] cur_q, prev_q, nx_q, head_q, fresh_q, free_q;
	logic              hit_q;
	logic [2:0]        res_st_q;
	logic [31:0]       res_rv_q;
	logic [2:0]        out_st_q;
	logic [31:0]       out_rv_q;
	logic [2:0]        dec_st;
	logic [31:0]       dec_rv;

	// ram ports
	logic              h_we;
	logic [BKT_W-1:0]  h_waddr, h_raddr;
	logic [NODE_W-1:0] h_wdata, h_rdata;
	logic              k_we, d_we, l_we;
	logic [PA_W-1:0]   k_waddr, d_waddr, l_waddr, n_raddr;
	logic [31:0]       k_wdata, d_wdata, k_rdata, d_rdata;
	logic [NODE_W-1:0] l_wdata, l_rdata;

	logic [NODE_W-1:0] h_node, l_next, ins_node;
	logic              match, ins, out_free;

	chp_ram #(.WIDTH(NODE_W), .DEPTH(BUCKETS)) u_head (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata));
	chp_ram #(.WIDTH(32), .DEPTH(POOL)) u_key (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
		.raddr(n_raddr), .rdata(k_rdata));
	chp_ram #(.WIDTH(32), .DEPTH(POOL)) u_data (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(n_raddr), .rdata(d_rdata));
	chp_ram #(.WIDTH(NODE_W), .DEPTH(POOL)) u_link (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(n_raddr), .rdata(l_rdata));

	// clipped links and the node that a put takes
	always_comb begin
		h_node   = (h_rdata >= NULL_NODE) ? NULL_NODE : h_rdata;
		l_next   = (l_rdata >= NULL_NODE) ? NULL_NODE : l_rdata;
		match    = (k_rdata == key_q);
		out_free = !m_tvalid || m_tready;
		ins      = (state_q == S_FREE) ||
			(state_q == S_DECIDE && op_q == OP_PUT && !hit_q &&
			 free_q == NULL_NODE && fresh_q < NULL_NODE);
		ins_node = (state_q == S_FREE) ? free_q : fresh_q;
	end

	// result decided after the walk
	always_comb begin
		dec_st = ST_NOT_FOUND;
		dec_rv = '0;
		case (op_q)
			OP_PUT: begin
				if (hit_q) dec_st = ST_UPDATED;
				else if (ins) dec_st = ST_INSERTED;
				else if (free_q == NULL_NODE) dec_st = ST_FULL;
			end
			OP_GET: begin
				if (hit_q) begin
					dec_st = ST_FOUND;
					dec_rv = dat_q;
				end else dec_rv = ABSENT_VALUE;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == BKT_W'(BUCKETS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (qout.valid) state_d = S_HEAD;
			end
			S_HEAD: begin
				state_d = (h_node == NULL_NODE) ? S_DECIDE : S_CMP;
			end
			S_CMP: begin
				if (match || l_next == NULL_NODE) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_DONE;
				if (op_q == OP_PUT && !hit_q && free_q != NULL_NODE) state_d = S_FREE;
				if (op_q == OP_REMOVE && hit_q) state_d = S_UNLINK;
			end
			S_FREE:   state_d = S_DONE;
			S_UNLINK: state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// ram addressing and writes
	always_comb begin
		pop     = (state_q == S_IDLE);
		h_raddr = qout.item.bkt;
		h_we    = 1'b0;
		h_waddr = bkt_q;
		h_wdata = ins_node;
		k_we    = ins;
		k_waddr = ins_node[PA_W-1:0];
		k_wdata = key_q;
		d_we    = ins;
		d_waddr = ins_node[PA_W-1:0];
		d_wdata = val_q;
		l_we    = ins;
		l_waddr = ins_node[PA_W-1:0];
		l_wdata = head_q;
		n_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				h_we    = 1'b1;
				h_waddr = clr_q;
				h_wdata = NULL_NODE;
			end
			S_HEAD:   n_raddr = h_node[PA_W-1:0];
			S_CMP:    n_raddr = l_next[PA_W-1:0];
			S_DECIDE: begin
				n_raddr = free_q[PA_W-1:0];
				if (ins) h_we = 1'b1;
				if (op_q == OP_PUT && hit_q) begin
					d_we    = 1'b1;
					d_waddr = cur_q[PA_W-1:0];
				end
				if (op_q == OP_REMOVE && hit_q) begin
					if (prev_q == NULL_NODE) begin
						h_we    = 1'b1;
						h_wdata = nx_q;
					end else begin
						l_we    = 1'b1;
						l_waddr = prev_q[PA_W-1:0];
						l_wdata = nx_q;
					end
				end
			end
			S_FREE:   h_we = 1'b1;
			S_UNLINK: begin
				l_we    = 1'b1;
				l_waddr = cur_q[PA_W-1:0];
				l_wdata = free_q;
			end
			default: ;
		endcase
	end

	// request fields and walk position
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			op_q  <= qout.item.op;
			key_q <= qout.item.key;
			val_q <= qout.item.value;
			bkt_q <= qout.item.bkt;
		end
		if (state_q == S_HEAD) begin
			head_q <= h_node;
			cur_q  <= h_node;
			prev_q <= NULL_NODE;
			hit_q  <= 1'b0;
		end
		if (state_q == S_CMP) begin
			if (match) begin
				hit_q <= 1'b1;
				nx_q  <= l_next;
				dat_q <= d_rdata;
			end else begin
				prev_q <= cur_q;
				cur_q  <= l_next;
			end
		end
	end

	// control state, pool bookkeeping and working result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			fresh_q  <= '0;
			free_q   <= NULL_NODE;
			res_st_q <= ST_NOT_FOUND;
			res_rv_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + BKT_W'(1);
			case (state_q)
				S_DECIDE: begin
					res_st_q <= dec_st;
					res_rv_q <= dec_rv;
					if (ins) fresh_q <= fresh_q + NODE_W'(1);
				end
				S_FREE: begin
					free_q   <= l_next;
					res_st_q <= ST_INSERTED;
				end
				S_UNLINK: begin
					free_q   <= cur_q;
					res_st_q <= ST_REMOVED;
				end
				default: ;
			endcase
		end
	end

	// output register, loaded when the walk ends and the previous result is gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			out_st_q <= ST_NOT_FOUND;
			out_rv_q <= '0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid <= 1'b1;
			out_st_q <= res_st_q;
			out_rv_q <= res_rv_q;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	assign m_tdata = out_rv_q;
	assign m_tuser = out_st_q;

endmodule

// ----- sv/chained_hash_table.sv -----
// top level of the chained hash table
//
// channel  dir  tdata (low bit up)     tuser
// s_*      in   key[31:0], value[63:32]  operation[1:0]
// m_*      out  read_value[31:0]        status[2:0]
//
// an item goes from the queue through the head read, one compare per chain node up to
// and including the matching node, the decision and the output register; a put that
// reuses a freed node and a remove that hits pass one more state (free or unlink). the
// walk is set by the registered read of the node memories.
// after reset a clearing pass writes all BUCKETS heads before the first item is
// worked; the two entry queue still takes transfers meanwhile.
// a held result stalls the walk only at its end, while the output register is
// still full; the queue keeps accepting until both its entries are taken.
module chained_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // key, value
	input  logic [1:0]  s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // read_value
	output logic [2:0]  m_tuser   // status
);
	import chp_pkg::*;

	queue_out_t qout;
	logic       pop;

	chp_front u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .qout(qout), .pop(pop));

	chp_back u_back (
		.clk(clk), .arst_n(arst_n), .qout(qout), .pop(pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser));

endmodule

// ----- tb/tb_chained_hash_table.sv -----
// self-checking testbench of the chained hash table: directed and random map traffic
`timescale 1ns / 100ps

module tb_chained_hash_table;
	import chp_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // key[31:0], value[63:32]
	logic [1:0]  s_tuser;   // operation[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // read_value[31:0]
	logic [2:0]  m_tuser;   // status[2:0]

	typedef struct {
		status_t     status;
		logic [31:0] read_value;
	} reply_t;

	// predicted map state
	logic [NODE_W-1:0] pred_head [BUCKETS];
	logic [31:0]       pred_key  [POOL];
	logic [31:0]       pred_data [POOL];
	logic [NODE_W-1:0] pred_link [POOL];
	int                pred_fresh;
	logic [NODE_W-1:0] pred_free;

	reply_t      pending_replies[$];
	int          error_count;
	int          items_sent;
	int          replies_seen;
	int          idle_cycles;
	int          burst_left;
	logic [31:0] known_keys[$];

	chained_hash_table u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// bucket of a key from its magnitude
	function automatic int bucket_index(logic [31:0] k);
		logic [31:0] mag;
		mag = k[31] ? (~k + 32'd1) : k;
		return int'(mag % BUCKETS);
	endfunction

	// apply one operation to the predicted map and return its reply
	function automatic reply_t map_apply(logic [1:0] op, logic [31:0] k, logic [31:0] v);
		reply_t r;
		int b;
		logic [NODE_W-1:0] cur, prev, hit, head, n;
		int steps;
		b = bucket_index(k);
		head = pred_head[b];
		cur = head;
		prev = NULL_NODE;
		hit = NULL_NODE;
		steps = 0;
		r.status = ST_NOT_FOUND;
		r.read_value = '0;
		while (cur != NULL_NODE && steps < POOL) begin
			if (pred_key[cur] == k) begin
				hit = cur;
				break;
			end
			prev = cur;
			cur = pred_link[cur];
			steps++;
		end
		case (op)
			OP_PUT: begin
				if (hit != NULL_NODE) begin
					pred_data[hit] = v;
					r.status = ST_UPDATED;
				end else begin
					n = NULL_NODE;
					if (pred_free != NULL_NODE) begin
						n = pred_free;
						pred_free = pred_link[n];
					end else if (pred_fresh < POOL) begin
						n = NODE_W'(pred_fresh);
						pred_fresh++;
					end
					if (n == NULL_NODE) r.status = ST_FULL;
					else begin
						pred_key[n] = k;
						pred_data[n] = v;
						pred_link[n] = head;
						pred_head[b] = n;
						r.status = ST_INSERTED;
					end
				end
			end
			OP_GET: begin
				if (hit != NULL_NODE) begin
					r.status = ST_FOUND;
					r.read_value = pred_data[hit];
				end else r.read_value = ABSENT_VALUE;
			end
			OP_REMOVE: begin
				if (hit != NULL_NODE) begin
					if (prev == NULL_NODE) pred_head[b] = pred_link[hit];
					else pred_link[prev] = pred_link[hit];
					pred_link[hit] = pred_free;
					pred_free = hit;
					r.status = ST_REMOVED;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// send one request with bursty gaps; prediction at the transfer
	task automatic send_request(logic [1:0] op, logic [31:0] k, logic [31:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {v, k};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_replies.push_back(map_apply(op, k, v));
		items_sent++;
		if (op == OP_PUT) known_keys.push_back(k);
	endtask

	// keys crowded into a few buckets so chains grow long
	function automatic logic [31:0] pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5 && known_keys.size() > 0)
			return known_keys[$urandom_range(0, known_keys.size() - 1)];
		if (sel < 8) return ($urandom_range(0, 15) * BUCKETS + $urandom_range(0, 3))
			* (($urandom_range(0, 1) != 0) ? -1 : 1);
		return $urandom;
	endfunction

	task automatic test_directed();
		send_request(OP_GET, 32'd5, 32'd0);
		send_request(OP_REMOVE, 32'd5, 32'd0);
		send_request(OP_PUT, 32'h8000_0000, 32'h8000_0000);
		send_request(OP_PUT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_request(OP_PUT, 32'd0, 32'hFFFF_FFFF);
		send_request(OP_PUT, 32'd1024, 32'd11);
		send_request(OP_PUT, -32'sd1024, 32'd12);
		send_request(OP_PUT, 32'd2048, 32'd13);
		send_request(OP_GET, 32'd0, 32'd0);
		send_request(OP_GET, 32'h8000_0000, 32'd0);
		send_request(OP_GET, 32'h7FFF_FFFF, 32'd0);
		send_request(OP_PUT, 32'd1024, 32'd99);
		send_request(OP_GET, 32'd1024, 32'd0);
		send_request(OP_REMOVE, 32'd1024, 32'd0);
		send_request(OP_GET, 32'd1024, 32'd0);
		send_request(OP_REMOVE, 32'd2048, 32'd0);
		send_request(OP_REMOVE, 32'd0, 32'd0);
		send_request(OP_PUT, 32'd3072, 32'd7);
		send_request(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_GET, -32'sd1024, 32'd0);
		send_request(OP_GET, 32'd3072, 32'd0);
	endtask

	task automatic test_random_mix(int count);
		int r;
		logic [1:0] op;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			op = (r < 45) ? OP_PUT : (r < 75) ? OP_GET : (r < 97) ? OP_REMOVE : OP_NONE;
			send_request(op, pick_key(), $urandom);
		end
	endtask

	// spread fresh keys over the pool, free some nodes, then reuse them
	task automatic test_churn();
		for (int i = 0; i < 200; i++) send_request(OP_PUT, $urandom, $urandom);
		for (int i = 0; i < 40; i++)
			send_request(OP_REMOVE, known_keys[$urandom_range(0, known_keys.size() - 1)],
				32'd0);
		for (int i = 0; i < 40; i++)
			send_request(($urandom_range(0, 1) != 0) ? OP_PUT : OP_GET, pick_key(), $urandom);
	endtask

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tready <= 1'b0;
		else if (($urandom_range(0, 255) & 8'hC0) == 8'hC0) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			replies_seen++;
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result status %0d value %h", $time, m_tuser, m_tdata);
				error_count++;
			end else begin
				if (m_tuser !== pending_replies[0].status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						pending_replies[0].status, m_tuser);
					error_count++;
				end
				if (m_tdata !== pending_replies[0].read_value) begin
					$display("%0t: read_value expected %h actual %h", $time,
						pending_replies[0].read_value, m_tdata);
					error_count++;
				end
				void'(pending_replies.pop_front());
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending_replies.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		error_count = 0;
		items_sent = 0;
		replies_seen = 0;
		idle_cycles = 0;
		burst_left = 0;
		for (int i = 0; i < BUCKETS; i++) pred_head[i] = NULL_NODE;
		pred_fresh = 0;
		pred_free = NULL_NODE;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(600);
		test_churn();
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("sent %0d requests, checked %0d results", items_sent, replies_seen);
		$display("covered put, get, remove, unused code, long chains and node reuse");
		if (error_count == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
sv/chp_pkg.sv
sv/chp_ram.sv
sv/chp_front.sv
sv/chp_back.sv
sv/chained_hash_table.sv
tb/tb_chained_hash_table.sv
